/* sv/sld_pkg.sv */
// shared types, constants and font table for the scrolling led character display
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

    localparam int CELL_COUNT    = 5;
    localparam int GLYPH_COLUMNS = 5;
    localparam int FONT_GLYPHS   = 95;

    localparam int CELL_STRIDE   = GLYPH_COLUMNS + 1;
    localparam int STORE_DEPTH   = CELL_COUNT * CELL_STRIDE;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);

    localparam int ROM_GLYPHS    = 95;
    localparam int ROM_COLUMNS   = 5;
    localparam int ROW_W         = 7;
    localparam int CODE_W        = 7;
    localparam int CELL_W        = 3;
    localparam int COL_W         = 3;
    localparam int LINES_W       = 5;
    localparam int STROBE_W      = 4;

    localparam logic [CODE_W-1:0]  FIRST_CODE  = 7'd32;
    localparam logic [CODE_W-1:0]  LAST_CODE   = 7'd126;
    localparam logic [LINES_W-1:0] COLUMN_IDLE = 5'h1F;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_SHIFT = 2'd1,
        KIND_SCAN  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [0:ROM_COLUMNS-1][ROW_W-1:0] glyph_t;

    // one column of a glyph, blank past the stored columns
    function automatic row_t glyph_column(input glyph_t g, input int unsigned k);
        row_t value;
        value = '0;
        if (k < ROM_COLUMNS)
        begin
            value = g[k];
        end
        return value;
    endfunction

    // font columns, left to right, indexed by code minus 32
    function automatic glyph_t font_glyph(input logic [CODE_W-1:0] g);
        glyph_t value;
        case (g)
            7'd0:  value = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
            7'd1:  value = {7'h00, 7'h5F, 7'h5F, 7'h00, 7'h00};
            7'd2:  value = {7'h00, 7'h07, 7'h00, 7'h07, 7'h00};
            7'd3:  value = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
            7'd4:  value = {7'h24, 7'h2A, 7'h7F, 7'h2A, 7'h12};
            7'd5:  value = {7'h23, 7'h13, 7'h08, 7'h64, 7'h62};
            7'd6:  value = {7'h36, 7'h49, 7'h55, 7'h22, 7'h50};
            7'd7:  value = {7'h00, 7'h05, 7'h03, 7'h00, 7'h00};
            7'd8:  value = {7'h00, 7'h1C, 7'h22, 7'h41, 7'h00};
            7'd9:  value = {7'h00, 7'h41, 7'h22, 7'h1C, 7'h00};
            7'd10: value = {7'h14, 7'h08, 7'h3E, 7'h08, 7'h14};
            7'd11: value = {7'h08, 7'h08, 7'h3E, 7'h08, 7'h08};
            7'd12: value = {7'h00, 7'h50, 7'h30, 7'h00, 7'h00};
            7'd13: value = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
            7'd14: value = {7'h00, 7'h60, 7'h60, 7'h00, 7'h00};
            7'd15: value = {7'h20, 7'h10, 7'h08, 7'h04, 7'h02};
            7'd16: value = {7'h3E, 7'h51, 7'h49, 7'h45, 7'h3E};
            7'd17: value = {7'h00, 7'h42, 7'h7F, 7'h40, 7'h00};
            7'd18: value = {7'h42, 7'h61, 7'h51, 7'h49, 7'h46};
            7'd19: value = {7'h22, 7'h49, 7'h49, 7'h49, 7'h36};
            7'd20: value = {7'h18, 7'h14, 7'h12, 7'h7F, 7'h10};
            7'd21: value = {7'h2F, 7'h49, 7'h49, 7'h49, 7'h31};
            7'd22: value = {7'h3E, 7'h49, 7'h49, 7'h49, 7'h32};
            7'd23: value = {7'h03, 7'h01, 7'h71, 7'h09, 7'h07};
            7'd24: value = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
            7'd25: value = {7'h26, 7'h49, 7'h49, 7'h49, 7'h3E};
            7'd26: value = {7'h00, 7'h36, 7'h36, 7'h00, 7'h00};
            7'd27: value = {7'h00, 7'h56, 7'h36, 7'h00, 7'h00};
            7'd28: value = {7'h08, 7'h14, 7'h22, 7'h41, 7'h00};
            7'd29: value = {7'h14, 7'h14, 7'h14, 7'h14, 7'h14};
            7'd30: value = {7'h00, 7'h41, 7'h22, 7'h14, 7'h08};
            7'd31: value = {7'h02, 7'h01, 7'h51, 7'h09, 7'h06};
            7'd32: value = {7'h32, 7'h49, 7'h79, 7'h41, 7'h3E};
            7'd33: value = {7'h7C, 7'h0A, 7'h09, 7'h0A, 7'h7C};
            7'd34: value = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h36};
            7'd35: value = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h22};
            7'd36: value = {7'h7F, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'd37: value = {7'h7F, 7'h49, 7'h49, 7'h49, 7'h41};
            7'd38: value = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h01};
            7'd39: value = {7'h3E, 7'h41, 7'h49, 7'h49, 7'h7A};
            7'd40: value = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
            7'd41: value = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
            7'd42: value = {7'h30, 7'h40, 7'h40, 7'h40, 7'h3F};
            7'd43: value = {7'h7F, 7'h08, 7'h14, 7'h22, 7'h41};
            7'd44: value = {7'h7F, 7'h40, 7'h40, 7'h40, 7'h40};
            7'd45: value = {7'h7F, 7'h02, 7'h0C, 7'h02, 7'h7F};
            7'd46: value = {7'h7F, 7'h02, 7'h04, 7'h08, 7'h7F};
            7'd47: value = {7'h3E, 7'h41, 7'h41, 7'h41, 7'h3E};
            7'd48: value = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h06};
            7'd49: value = {7'h3E, 7'h41, 7'h51, 7'h21, 7'h5E};
            7'd50: value = {7'h7F, 7'h09, 7'h09, 7'h09, 7'h76};
            7'd51: value = {7'h26, 7'h49, 7'h49, 7'h49, 7'h32};
            7'd52: value = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
            7'd53: value = {7'h3F, 7'h40, 7'h40, 7'h40, 7'h3F};
            7'd54: value = {7'h1F, 7'h20, 7'h40, 7'h20, 7'h1F};
            7'd55: value = {7'h3F, 7'h40, 7'h38, 7'h40, 7'h3F};
            7'd56: value = {7'h63, 7'h14, 7'h08, 7'h14, 7'h63};
            7'd57: value = {7'h03, 7'h04, 7'h78, 7'h04, 7'h03};
            7'd58: value = {7'h61, 7'h51, 7'h49, 7'h45, 7'h43};
            7'd59: value = {7'h7F, 7'h41, 7'h41, 7'h00, 7'h00};
            7'd60: value = {7'h02, 7'h04, 7'h08, 7'h10, 7'h20};
            7'd61: value = {7'h00, 7'h41, 7'h41, 7'h7F, 7'h00};
            7'd62: value = {7'h04, 7'h02, 7'h01, 7'h02, 7'h04};
            7'd63: value = {7'h40, 7'h40, 7'h40, 7'h40, 7'h40};
            7'd64: value = {7'h00, 7'h01, 7'h02, 7'h04, 7'h00};
            7'd65: value = {7'h20, 7'h54, 7'h54, 7'h54, 7'h78};
            7'd66: value = {7'h7F, 7'h48, 7'h44, 7'h44, 7'h38};
            7'd67: value = {7'h38, 7'h44, 7'h44, 7'h44, 7'h20};
            7'd68: value = {7'h38, 7'h44, 7'h44, 7'h48, 7'h7F};
            7'd69: value = {7'h38, 7'h54, 7'h54, 7'h54, 7'h18};
            7'd70: value = {7'h08, 7'h7E, 7'h09, 7'h01, 7'h02};
            7'd71: value = {7'h0C, 7'h52, 7'h52, 7'h52, 7'h3E};
            7'd72: value = {7'h7F, 7'h08, 7'h04, 7'h04, 7'h78};
            7'd73: value = {7'h00, 7'h44, 7'h7D, 7'h40, 7'h00};
            7'd74: value = {7'h20, 7'h40, 7'h44, 7'h3D, 7'h00};
            7'd75: value = {7'h7F, 7'h10, 7'h28, 7'h44, 7'h00};
            7'd76: value = {7'h00, 7'h41, 7'h7F, 7'h40, 7'h00};
            7'd77: value = {7'h7C, 7'h04, 7'h18, 7'h04, 7'h78};
            7'd78: value = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h78};
            7'd79: value = {7'h38, 7'h44, 7'h44, 7'h44, 7'h38};
            7'd80: value = {7'h7C, 7'h14, 7'h14, 7'h14, 7'h08};
            7'd81: value = {7'h08, 7'h14, 7'h14, 7'h18, 7'h7C};
            7'd82: value = {7'h7C, 7'h08, 7'h04, 7'h04, 7'h08};
            7'd83: value = {7'h48, 7'h54, 7'h54, 7'h54, 7'h20};
            7'd84: value = {7'h04, 7'h3F, 7'h44, 7'h40, 7'h20};
            7'd85: value = {7'h3C, 7'h40, 7'h40, 7'h20, 7'h7C};
            7'd86: value = {7'h1C, 7'h20, 7'h40, 7'h20, 7'h1C};
            7'd87: value = {7'h3C, 7'h40, 7'h38, 7'h40, 7'h3C};
            7'd88: value = {7'h44, 7'h28, 7'h10, 7'h28, 7'h44};
            7'd89: value = {7'h0C, 7'h50, 7'h50, 7'h50, 7'h3C};
            7'd90: value = {7'h44, 7'h64, 7'h54, 7'h4C, 7'h44};
            7'd91: value = {7'h00, 7'h08, 7'h36, 7'h41, 7'h00};
            7'd92: value = {7'h00, 7'h00, 7'h7F, 7'h00, 7'h00};
            7'd93: value = {7'h00, 7'h41, 7'h36, 7'h08, 7'h00};
            7'd94: value = {7'h08, 7'h04, 7'h08, 7'h10, 7'h08};
            default: value = '0;
        endcase
        return value;
    endfunction

endpackage

`default_nettype wire

/* sv/scrolling_led_character_display_top.sv */
// scrolling led character display: column store, font lookup, shift and column scan
// a scan item passes through the input register, then the result register, before its
// result shows; load and shift items give no result
// throughput: one item per cycle, set by the single pass between the input register and
// the column store and result register; a scan waiting behind a stalled result holds the input
// reset: asynchronous active-low reset clears the column store and all valid flags
`timescale 1ns / 1ps
`default_nettype none

module scrolling_led_character_display_top
    import sld_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          kind,
    input  wire logic [CODE_W-1:0]   char_code,
    input  wire logic [CELL_W-1:0]   display_index,
    input  wire logic [COL_W-1:0]    column_index,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [LINES_W-1:0]       column_lines,
    output logic [ROW_W-1:0]         row_data,
    output logic [STROBE_W-1:0]      latch_strobe
);

    // input register
    logic                in_valid_reg, in_valid_next;
    kind_t               kind_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [COL_W-1:0]    col_reg;

    // column store
    row_t                store_reg  [STORE_DEPTH];
    row_t                store_next [STORE_DEPTH];

    // result register
    logic                out_valid_reg, out_valid_next;
    logic [LINES_W-1:0]  lines_reg, lines_next;
    row_t                row_reg, row_next;
    logic [STROBE_W-1:0] strobe_reg, strobe_next;

    logic                in_accept;
    logic                exec;
    logic                scan_fire;
    logic [CODE_W-1:0]   glyph_idx;
    logic                glyph_ok;
    glyph_t              glyph;
    logic [STORE_AW-1:0] scan_pos;

    assign exec      = in_valid_reg &&
                       ((kind_reg != KIND_SCAN) || !out_valid_reg || !out_stall);
    assign scan_fire = exec && (kind_reg == KIND_SCAN);
    assign in_stall  = in_valid_reg && !exec;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next = in_accept ? 1'b1 : (exec ? 1'b0 : in_valid_reg);

    // font lookup
    assign glyph_idx = code_reg - FIRST_CODE;
    assign glyph_ok  = (code_reg >= FIRST_CODE) && (code_reg <= LAST_CODE) &&
                       (32'(glyph_idx) < FONT_GLYPHS) && (32'(glyph_idx) < ROM_GLYPHS);
    assign glyph     = glyph_ok ? font_glyph(glyph_idx) : glyph_t'(0);

    // store update
    always_comb
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (exec)
        begin
            unique case (kind_reg)
                KIND_LOAD:
                begin
                    for (int c = 0; c < CELL_COUNT; c++)
                    begin
                        if (32'(cell_reg) == c)
                        begin
                            for (int k = 0; k < CELL_STRIDE; k++)
                            begin
                                store_next[c * CELL_STRIDE + k] = (k < GLYPH_COLUMNS) ?
                                    glyph_column(glyph, k) : row_t'(0);
                            end
                        end
                    end
                end
                KIND_SHIFT:
                begin
                    for (int i = 1; i < STORE_DEPTH; i++)
                    begin
                        store_next[i - 1] = store_reg[i];
                    end
                end
                KIND_SCAN, KIND_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // scan result
    assign scan_pos = STORE_AW'(32'(cell_reg) * CELL_STRIDE + (GLYPH_COLUMNS - 1)
                                - 32'(col_reg));

    always_comb
    begin
        lines_next     = lines_reg;
        row_next       = row_reg;
        strobe_next    = strobe_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (scan_fire)
        begin
            out_valid_next = 1'b1;
            lines_next     = COLUMN_IDLE;
            if (32'(col_reg) < LINES_W)
            begin
                lines_next = COLUMN_IDLE & ~(LINES_W'(1) << col_reg);
            end
            row_next = '0;
            if ((32'(cell_reg) < CELL_COUNT) && (32'(col_reg) < GLYPH_COLUMNS))
            begin
                row_next = store_reg[scan_pos];
            end
            strobe_next = '0;
            if ((32'(cell_reg) < STROBE_W) && (32'(cell_reg) < CELL_COUNT))
            begin
                strobe_next = STROBE_W'(1) << cell_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg <= kind_t'(kind);
            code_reg <= char_code;
            cell_reg <= display_index;
            col_reg  <= column_index;
        end
        lines_reg  <= lines_next;
        row_reg    <= row_next;
        strobe_reg <= strobe_next;
    end

    assign out_valid    = out_valid_reg;
    assign column_lines = lines_reg;
    assign row_data     = row_reg;
    assign latch_strobe = strobe_reg;

    // checks
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("stall raised with empty input register");

    a_scan_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        scan_fire |=> out_valid_reg)
        else $error("scan item produced no result");

    a_strobe_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0(strobe_reg))
        else $error("latch strobe not one-hot");

    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones(~lines_reg) <= 1))
        else $error("more than one column driven");

    a_shift_keeps_tail: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (kind_reg == KIND_SHIFT)) |=> $stable(store_reg[STORE_DEPTH-1]))
        else $error("shift changed last store byte");

endmodule

`default_nettype wire
